FILE: src/zone_lookup_smoothstep_blend_defines.svh
// Assertion macros shared by the zone lookup checker.
// No dependencies; included by the checker file only.
`ifndef ZONE_LOOKUP_SMOOTHSTEP_BLEND_DEFINES_SVH
`define ZONE_LOOKUP_SMOOTHSTEP_BLEND_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet in reset
`define ZLSB_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("zlsb: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet in reset
`define ZLSB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("zlsb: next-cycle check failed");

`endif

FILE: src/zlsb_pkg.sv
// Shared constants and types for the zone lookup / smoothstep blend block.
// No dependencies; imported by the divider and the top-level module.
package zlsb_pkg;

    localparam int MAX_ZONES_DEF  = 16;
    localparam int VALUE_BITS_DEF = 24;

    // Fixed-point constants (weights in Q1.16, positions in Q16.8)
    localparam int WIDTH_CAP  = 1024;
    localparam int ONE_Q16    = 65536;
    localparam int THREE_Q16  = 3 * ONE_Q16;

    // Blend width is at most WIDTH_CAP, the divisor 2*w one bit more
    localparam int W_BITS     = 11;
    localparam int DEN_BITS   = 12;
    localparam int Q_BITS     = 16;
    localparam int T_BITS     = 17;
    localparam int COEF_BITS  = 19;

    // Register index of zone_count on the configuration port
    localparam logic REG_ZONE_COUNT = 1'b0;

    // Input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                start;
        logic [DEN_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [Q_BITS-1:0] quo;
    } div_rsp_t;

endpackage

FILE: src/zlsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the zone table.
module zlsb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/zlsb_div.sv
// Restoring divider for the blend weight: one quotient bit per cycle.
// Depends on zlsb_pkg (request and response structs).
module zlsb_div
    import zlsb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]   quo_reg;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;

    // Remainder stays below the divisor, so one spare bit is enough
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};

    // Control: a start sets busy and loads the step counter; busy clears when it runs out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: shift, compare, conditional subtract
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= DEN_BITS'(diff);
                quo_reg <= {quo_reg[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= DEN_BITS'(shifted);
                quo_reg <= {quo_reg[Q_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: src/zone_lookup_smoothstep_blend.sv
// Zone lookup with smoothstep blending. A load transaction writes one zone of
// the table. A query binary-searches the zone table through the single RAM
// read port (at most ceil(log2(zone_count)) probes), reads the found, previous
// and next zones, sizes the blend, and then either finishes at once when
// unblended or runs the weight through the bit-serial divider (only when the
// weight is fractional) and four passes of the one shared multiplier. The
// block holds stall while a query is worked.
module zone_lookup_smoothstep_blend
    import zlsb_pkg::*;
#(
    parameter int MAX_ZONES  = MAX_ZONES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [3:0]                   zone_slot,
    input  logic signed [VALUE_BITS-1:0] zone_begin_x,
    input  logic signed [VALUE_BITS-1:0] zone_end_x,
    input  logic signed [VALUE_BITS-1:0] zone_temperature,
    input  logic signed [VALUE_BITS-1:0] zone_transfer,
    input  logic signed [VALUE_BITS-1:0] position,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   found_zone,
    output logic signed [VALUE_BITS-1:0] blended_temperature,
    output logic signed [VALUE_BITS-1:0] blended_transfer,
    output logic                         was_blended
);

    localparam int VB   = VALUE_BITS;
    localparam int IW   = $clog2(MAX_ZONES);
    localparam int RW   = 4 * VB;
    localparam int MA_W = (VB + 1 > T_BITS + 1) ? VB + 1 : T_BITS + 1;
    localparam int PW   = MA_W + COEF_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_RD3  = 4'd6;
    localparam logic [3:0] S_WID  = 4'd7;
    localparam logic [3:0] S_DEC  = 4'd8;
    localparam logic [3:0] S_SEL  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_MT   = 4'd11;
    localparam logic [3:0] S_MS   = 4'd12;
    localparam logic [3:0] S_MA   = 4'd13;
    localparam logic [3:0] S_MB   = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    // control
    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg;
    logic [4:0]  zone_count_reg;
    logic        accept;
    logic        take_out;
    logic        load_out;

    // search
    logic signed [VB-1:0] x_reg;
    logic [IW:0]          cnt_reg;
    logic [IW-1:0]        lo_reg, hi_reg, mid_reg;
    logic [IW:0]          mid_sum;
    logic [8:0]           count_ext;
    logic [IW:0]          cnt_in;

    // zone entries and lengths
    logic signed [VB-1:0] cur_b, cur_e, cur_t, cur_x;
    logic signed [VB-1:0] prev_t, prev_x, next_t, next_x;
    logic signed [VB:0]   len_p, len_c, len_n, len_rd;
    logic [W_BITS-1:0]    wp_reg, wn_reg;
    logic signed [VB+1:0] nump_reg, numn_reg;

    // blend datapath
    logic signed [VB-1:0]    a_t, a_x;
    logic signed [VB:0]      d_t, d_x;
    logic [T_BITS-1:0]       t_reg;
    logic [COEF_BITS-1:0]    coef_reg;
    logic [T_BITS-1:0]       s_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [VB-1:0]    temp_reg;
    logic                    blend_reg;

    // RAM
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic signed [VB-1:0] rd_b, rd_e, rd_t, rd_x;

    // selection
    logic                  sel_p, sel_n, sel_any;
    logic signed [VB+1:0]  sel_num;
    logic [DEN_BITS-1:0]   sel_den;
    logic signed [VB-1:0]  sel_at, sel_ax, sel_bt, sel_bx;
    logic                  sel_zero, sel_full;
    logic                  next_ok;

    // shared multiplier
    logic signed [MA_W-1:0]      mul_a;
    logic signed [COEF_BITS-1:0] mul_b;
    logic signed [PW-1:0]        mul_p;

    div_req_t div_req;
    div_rsp_t div_rsp;

    function automatic logic [W_BITS-1:0] bwidth(input logic signed [VB:0] la,
                                                 input logic signed [VB:0] lb);
        logic signed [VB:0] m;
        logic signed [VB:0] q;
        m = (la < lb) ? la : lb;
        q = m >>> 2;
        if (m <= 0)
            bwidth = '0;
        else if (q > (VB+1)'(WIDTH_CAP))
            bwidth = W_BITS'(WIDTH_CAP);
        else
            bwidth = W_BITS'(q);
    endfunction

    // APB register: zone_count
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ZONE_COUNT) ? {27'd0, zone_count_reg} : 32'd0;

    // Handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign take_out  = out_valid_reg && !out_stall;
    assign load_out  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Zone table
    assign ram_we    = accept && (func == FUNC_LOAD) && (9'(zone_slot) < 9'(MAX_ZONES));
    assign ram_waddr = IW'(zone_slot);
    assign ram_wdata = {zone_begin_x, zone_end_x, zone_temperature, zone_transfer};
    assign rd_b      = $signed(ram_rdata[4*VB-1:3*VB]);
    assign rd_e      = $signed(ram_rdata[3*VB-1:2*VB]);
    assign rd_t      = $signed(ram_rdata[2*VB-1:VB]);
    assign rd_x      = $signed(ram_rdata[VB-1:0]);
    assign len_rd    = (VB+1)'(rd_e) - (VB+1)'(rd_b);

    zlsb_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ZONES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Search helpers
    assign count_ext = 9'(zone_count_reg);
    assign cnt_in    = (count_ext > 9'(MAX_ZONES)) ? (IW+1)'(MAX_ZONES) : (IW+1)'(count_ext);
    assign mid_sum   = (IW+1)'(lo_reg) + (IW+1)'(hi_reg);
    assign next_ok   = ((IW+1)'(lo_reg) + (IW+1)'(1)) < cnt_reg;

    // Read address per state
    always_comb
    begin
        case (state_reg)
            S_SRCH:  ram_raddr = IW'(mid_sum >> 1);
            S_RD0:   ram_raddr = lo_reg;
            S_RD1:   ram_raddr = lo_reg - IW'(1);
            S_RD2:   ram_raddr = lo_reg + IW'(1);
            default: ram_raddr = mid_reg;
        endcase
    end

    // Boundary choice: previous zone first, then next zone
    always_comb
    begin
        sel_p   = (lo_reg != '0) && (wp_reg != '0) &&
                  (nump_reg < (VB+2)'($signed({1'b0, wp_reg, 1'b0})));
        sel_n   = next_ok && (wn_reg != '0) && (numn_reg > 0);
        sel_any = sel_p || sel_n;
        if (sel_p)
        begin
            sel_num = nump_reg;
            sel_den = {wp_reg, 1'b0};
            sel_at  = prev_t;
            sel_ax  = prev_x;
            sel_bt  = cur_t;
            sel_bx  = cur_x;
        end
        else
        begin
            sel_num = numn_reg;
            sel_den = {wn_reg, 1'b0};
            sel_at  = cur_t;
            sel_ax  = cur_x;
            sel_bt  = next_t;
            sel_bx  = next_x;
        end
        sel_zero = (sel_num <= 0);
        sel_full = (sel_num >= (VB+2)'($signed({1'b0, sel_den})));
    end

    assign div_req.start = (state_reg == S_SEL) && sel_any && !sel_zero && !sel_full;
    assign div_req.num   = DEN_BITS'(sel_num);
    assign div_req.den   = sel_den;

    zlsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MT:
            begin
                mul_a = MA_W'($signed({1'b0, t_reg}));
                mul_b = COEF_BITS'($signed({1'b0, t_reg}));
            end
            S_MS:
            begin
                mul_a = MA_W'($signed({1'b0, prod_reg[32:16]}));
                mul_b = $signed(coef_reg);
            end
            S_MA:
            begin
                mul_a = MA_W'(d_t);
                mul_b = COEF_BITS'($signed({1'b0, prod_reg[32:16]}));
            end
            default:
            begin
                mul_a = MA_W'(d_x);
                mul_b = COEF_BITS'($signed({1'b0, s_reg}));
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept && (func == FUNC_QUERY)) state_next = S_SRCH;
            S_SRCH: state_next = (lo_reg < hi_reg) ? S_SCMP : S_RD0;
            S_SCMP: state_next = S_SRCH;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_WID;
            S_WID:  state_next = S_DEC;
            S_DEC:  state_next = S_SEL;
            S_SEL:
            begin
                if (!sel_any)
                    state_next = S_FIN;
                else if (sel_zero || sel_full)
                    state_next = S_MT;
                else
                    state_next = S_DIV;
            end
            S_DIV:  if (!div_rsp.busy) state_next = S_MT;
            S_MT:   state_next = S_MS;
            S_MS:   state_next = S_MA;
            S_MA:   state_next = S_MB;
            S_MB:   state_next = S_FIN;
            S_FIN:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            zone_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (take_out)
                out_valid_reg <= 1'b0;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_ZONE_COUNT))
                zone_count_reg <= pwdata[4:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg   <= position;
                cnt_reg <= cnt_in;
                lo_reg  <= '0;
                hi_reg  <= (cnt_in != '0) ? IW'(cnt_in - (IW+1)'(1)) : '0;
            end
            S_SRCH: mid_reg <= IW'(mid_sum >> 1);
            S_SCMP:
            begin
                if (x_reg < rd_e)
                    hi_reg <= mid_reg;
                else
                    lo_reg <= mid_reg + IW'(1);
            end
            S_RD1:
            begin
                cur_b <= rd_b;
                cur_e <= rd_e;
                cur_t <= rd_t;
                cur_x <= rd_x;
                len_c <= len_rd;
            end
            S_RD2:
            begin
                prev_t <= rd_t;
                prev_x <= rd_x;
                len_p  <= len_rd;
            end
            S_RD3:
            begin
                next_t <= rd_t;
                next_x <= rd_x;
                len_n  <= len_rd;
            end
            S_WID:
            begin
                wp_reg <= bwidth(len_p, len_c);
                wn_reg <= bwidth(len_c, len_n);
            end
            S_DEC:
            begin
                nump_reg <= (VB+2)'(x_reg) - (VB+2)'(cur_b) + (VB+2)'($signed({1'b0, wp_reg}));
                numn_reg <= (VB+2)'(x_reg) - (VB+2)'(cur_e) + (VB+2)'($signed({1'b0, wn_reg}));
            end
            S_SEL:
            begin
                blend_reg <= sel_any;
                a_t       <= sel_any ? sel_at : cur_t;
                a_x       <= sel_any ? sel_ax : cur_x;
                temp_reg  <= cur_t;
                d_t       <= (VB+1)'(sel_bt) - (VB+1)'(sel_at);
                d_x       <= (VB+1)'(sel_bx) - (VB+1)'(sel_ax);
                t_reg     <= sel_zero ? '0 : T_BITS'(ONE_Q16);
            end
            S_DIV: t_reg <= {1'b0, div_rsp.quo};
            S_MT:
            begin
                prod_reg <= mul_p;
                coef_reg <= COEF_BITS'(THREE_Q16) - COEF_BITS'({t_reg, 1'b0});
            end
            S_MS: prod_reg <= mul_p;
            S_MA:
            begin
                prod_reg <= mul_p;
                s_reg    <= prod_reg[32:16];
            end
            S_MB:
            begin
                prod_reg <= mul_p;
                temp_reg <= a_t + VB'(prod_reg >>> 16);
            end
            default:
            begin
            end
        endcase

        // Result register, held while the result transaction stalls
        if (load_out)
        begin
            found_zone          <= 4'(lo_reg);
            blended_temperature <= temp_reg;
            blended_transfer    <= blend_reg ? a_x + VB'(prod_reg >>> 16) : a_x;
            was_blended         <= blend_reg;
        end
    end

endmodule

FILE: src/zlsb_checker.sv
// Port-level checker for the zone lookup block, bound to its top level.
// Depends on zone_lookup_smoothstep_blend_defines.svh for the assertion macros.
`include "zone_lookup_smoothstep_blend_defines.svh"

module zlsb_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic func,
    input logic out_valid,
    input logic out_stall
);

    // A pending result survives a stall
    `ZLSB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // A query transaction occupies the block
    `ZLSB_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && func, in_stall)
    // A load leaves the block free and produces nothing
    `ZLSB_ASSERT_NEXT(a_load_free, in_valid && !in_stall && !func, !in_stall)
    `ZLSB_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && !func && !out_valid, !out_valid)

endmodule

bind zone_lookup_smoothstep_blend zlsb_port_checker u_zlsb_checker (.*);
